// ===== sv/fixed_block_pool_allocator_unit_assert.svh =====
// assertion macros for the fixed block pool allocator
// used by the top level only; no other dependencies
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define FBPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbpa assertion failed");
`define FBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");
`else
`define FBPA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define FBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/fbpa_pkg.sv =====
// shared types and constants for the fixed block pool allocator
// used by the front, queue, back and top level; no dependencies
package fbpa_pkg;

  localparam int SPAN_W   = 25;
  localparam int QUO_W    = 9;
  localparam int CFG_AW   = 4;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REFILL = 2'd2;

  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]        op;
    status_t           pre;
    logic [SPAN_W-1:0] off;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_ADDR,
    B_DIV,
    B_PUSH,
    B_DONE
  } back_state_t;

endpackage

// ===== sv/fbpa_front.sv =====
// front end: registers a request and classifies free addresses
// depends on fbpa_pkg for the command transaction and status codes
module fbpa_front #(
  parameter int ADDR_BITS = 32,
  parameter int CNT_W     = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       op,
  input  logic [31:0]      block_addr,
  input  logic [31:0]      pool_base,
  input  logic [15:0]      block_size,
  input  logic [CNT_W-1:0] cnt,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output fbpa_pkg::cmd_t   cmd
);

  localparam int XW    = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int SPW   = CNT_W + 16;
  localparam int CW    = (ADDR_BITS > SPW) ? ADDR_BITS : SPW;
  localparam int OFF_W = fbpa_pkg::SPAN_W;

  logic [XW-1:0]        addr_x;
  logic [XW-1:0]        base_x;
  logic [ADDR_BITS-1:0] base;
  logic [ADDR_BITS-1:0] off;
  logic                 s1_valid;
  logic [1:0]           s1_op;
  logic [ADDR_BITS-1:0] s1_a;
  logic [SPW-1:0]       span;
  logic                 is_null;
  logic                 out_of_range;

  assign addr_x = XW'(block_addr);
  assign base_x = XW'(pool_base);
  assign base   = base_x[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    span <= SPW'(cnt) * SPW'(block_size);
    if (accept) begin
      s1_op <= op;
      s1_a  <= addr_x[ADDR_BITS-1:0];
    end
  end

  assign off          = s1_a - base;
  assign is_null      = (s1_a == '0);
  assign out_of_range = (s1_a < base) || (CW'(off) >= CW'(span));

  always_comb begin
    cmd.op  = s1_op;
    cmd.off = OFF_W'(off);
    cmd.pre = fbpa_pkg::ST_OK;
    if (s1_op == fbpa_pkg::OP_FREE) begin
      if (is_null) begin
        cmd.pre = fbpa_pkg::ST_NULL;
      end else if (out_of_range) begin
        cmd.pre = fbpa_pkg::ST_RANGE;
      end
    end
  end

  assign push = s1_valid & ~q_full;
  assign busy = s1_valid;

endmodule

// ===== sv/fbpa_queue.sv =====
// two-entry command queue between the front and back ends
// depends on fbpa_pkg for the command transaction type
module fbpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fbpa_pkg::cmd_t cmd_in,
  input  logic           pop,
  output fbpa_pkg::cmd_t cmd_out,
  output logic           valid,
  output logic           full
);

  fbpa_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  assign cmd_out = entry[rd_ptr];
  assign valid   = (count != 2'd0);
  assign full    = (count == 2'd2);

endmodule

// ===== sv/fbpa_back.sv =====
// back end: free index ring, block index divider and result register
// depends on fbpa_pkg for the command transaction, states and status codes
module fbpa_back #(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_BITS  = 32,
  parameter int CNT_W      = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  fbpa_pkg::cmd_t   q_cmd,
  output logic             pop,
  input  logic [31:0]      pool_base,
  input  logic [15:0]      block_size,
  input  logic [CNT_W-1:0] cnt,
  output logic             busy,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      alloc_addr,
  output logic [8:0]       free_blocks,
  output logic [8:0]       used_blocks
);

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int PW      = IDX_W + 16;
  localparam int SUMW    = (ADDR_BITS > PW) ? ADDR_BITS : PW;
  localparam int XW      = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int SW      = fbpa_pkg::SPAN_W;
  localparam int QW      = fbpa_pkg::QUO_W;
  localparam int STEP_W  = $clog2(QW);
  localparam int RST_CNT = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

  fbpa_pkg::back_state_t state;
  fbpa_pkg::back_state_t state_next;
  fbpa_pkg::status_t     res_status;

  logic [IDX_W-1:0]     ring [MAX_BLOCKS];
  logic [IDX_W-1:0]     rd_q;
  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     free_total;
  logic [PW-1:0]        prod_q;
  logic [SW-1:0]        rem;
  logic [SW-1:0]        dvs;
  logic [QW-1:0]        quo;
  logic [STEP_W-1:0]    step;
  logic [ADDR_BITS-1:0] res_addr;

  logic [CNT_W:0]       head_inc;
  logic [CNT_W:0]       tail_inc;
  logic [IDX_W-1:0]     head_adv;
  logic [IDX_W-1:0]     tail_adv;
  logic [IDX_W-1:0]     idx;
  logic [SW:0]          diff;
  logic                 ge;
  logic [XW-1:0]        base_x;
  logic [SUMW-1:0]      sum;
  logic [XW-1:0]        res_x;
  logic                 push_ok;
  logic                 ring_we;

  assign head_inc = (CNT_W + 1)'(head) + (CNT_W + 1)'(1);
  assign tail_inc = (CNT_W + 1)'(tail) + (CNT_W + 1)'(1);
  assign head_adv = (head_inc >= {1'b0, cnt}) ? '0 : head_inc[IDX_W-1:0];
  assign tail_adv = (tail_inc >= {1'b0, cnt}) ? '0 : tail_inc[IDX_W-1:0];

  // entries at or past the fill mark still hold their reset index
  assign idx = (CNT_W'(head) < fill) ? rd_q : head;

  assign diff   = {1'b0, rem} - {1'b0, dvs};
  assign ge     = ~diff[SW];
  assign base_x = XW'(pool_base);
  assign sum    = SUMW'(base_x[ADDR_BITS-1:0]) + SUMW'(prod_q);
  assign res_x  = XW'(res_addr);

  assign push_ok = (rem == '0) && (free_total < cnt);
  assign ring_we = (state == fbpa_pkg::B_PUSH) && push_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbpa_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      fbpa_pkg::B_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_cmd.op)
            fbpa_pkg::OP_ALLOC: begin
              state_next = (free_total == '0) ? fbpa_pkg::B_DONE : fbpa_pkg::B_READ;
            end
            fbpa_pkg::OP_FREE: begin
              state_next = (q_cmd.pre == fbpa_pkg::ST_OK) ? fbpa_pkg::B_DIV
                                                           : fbpa_pkg::B_DONE;
            end
            default: state_next = fbpa_pkg::B_DONE;
          endcase
        end
      end
      fbpa_pkg::B_READ: state_next = fbpa_pkg::B_ADDR;
      fbpa_pkg::B_ADDR: state_next = fbpa_pkg::B_DONE;
      fbpa_pkg::B_DIV: begin
        if (step == '0) begin
          state_next = fbpa_pkg::B_PUSH;
        end
      end
      fbpa_pkg::B_PUSH: state_next = fbpa_pkg::B_DONE;
      fbpa_pkg::B_DONE: state_next = fbpa_pkg::B_IDLE;
      default:          state_next = fbpa_pkg::B_IDLE;
    endcase
  end

  assign busy = (state != fbpa_pkg::B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      free_total <= CNT_W'(RST_CNT);
      done       <= 1'b0;
    end else begin
      done <= (state == fbpa_pkg::B_DONE);
      case (state)
        fbpa_pkg::B_IDLE: begin
          if (q_valid && (q_cmd.op == fbpa_pkg::OP_REFILL)) begin
            head       <= '0;
            tail       <= '0;
            fill       <= '0;
            free_total <= cnt;
          end
        end
        fbpa_pkg::B_READ: begin
          head       <= head_adv;
          free_total <= free_total - CNT_W'(1);
        end
        fbpa_pkg::B_PUSH: begin
          if (push_ok) begin
            tail       <= tail_adv;
            free_total <= free_total + CNT_W'(1);
            if (tail_inc[CNT_W-1:0] > fill) begin
              fill <= tail_inc[CNT_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fbpa_pkg::B_IDLE: begin
        if (q_valid) begin
          res_addr <= '0;
          rem      <= q_cmd.off;
          dvs      <= SW'(block_size) << (QW - 1);
          quo      <= '0;
          step     <= STEP_W'(QW - 1);
          case (q_cmd.op)
            fbpa_pkg::OP_ALLOC: begin
              res_status <= (free_total == '0) ? fbpa_pkg::ST_EMPTY : fbpa_pkg::ST_OK;
            end
            fbpa_pkg::OP_FREE: res_status <= q_cmd.pre;
            default:           res_status <= fbpa_pkg::ST_OK;
          endcase
        end
      end
      fbpa_pkg::B_READ: begin
        prod_q <= PW'(idx) * PW'(block_size);
      end
      fbpa_pkg::B_ADDR: begin
        res_addr <= sum[ADDR_BITS-1:0];
      end
      fbpa_pkg::B_DIV: begin
        if (ge) begin
          rem <= diff[SW-1:0];
        end
        quo  <= {quo[QW-2:0], ge};
        dvs  <= dvs >> 1;
        step <= step - STEP_W'(1);
      end
      fbpa_pkg::B_PUSH: begin
        if (rem != '0) begin
          res_status <= fbpa_pkg::ST_MISALIGN;
        end else if (free_total >= cnt) begin
          res_status <= fbpa_pkg::ST_FULL;
        end
      end
      fbpa_pkg::B_DONE: begin
        status      <= res_status;
        alloc_addr  <= res_x[31:0];
        free_blocks <= 9'(free_total);
        used_blocks <= (free_total <= cnt) ? 9'(cnt - free_total) : 9'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[tail] <= IDX_W'(quo);
    end
    rd_q <= ring[head];
  end

endmodule

// ===== sv/fixed_block_pool_allocator_unit.sv =====
// Fixed block pool allocator. Requests enter on a start/busy command port and
// results leave on a one-cycle done strobe. Configuration sits behind an APB
// port: pool_base at 0x0, block_size at 0x4, block_count at 0x8.
// A request is accepted at a clock edge with start high and busy low. Results
// appear on done for exactly one cycle and cannot be held off by the receiver.
// From accept to done strobe, a granted allocate reads the ring and forms
// the address, a free that passes the null and range checks runs the 9-step
// restoring divider that turns the block offset into an index and remainder
// and then tries to push the index, and everything else goes straight to done.
// Busy falls in the done cycle, so the next request can be accepted there.
// Reset restores the default configuration (base 0x10000, 64-byte blocks,
// 256 blocks) and a full ring of free indices in order; no clearing pass runs.
// Depends on fbpa_pkg, fbpa_front, fbpa_queue, fbpa_back and the assert header.
module fixed_block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = 256,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] block_addr,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] alloc_addr,
  output logic [8:0]  free_blocks,
  output logic [8:0]  used_blocks
);

  `include "fixed_block_pool_allocator_unit_assert.svh"

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [31:0]      pool_base;
  logic [15:0]      block_size;
  logic [8:0]       block_count;
  logic             cfg_wr;
  logic             over;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             front_busy;
  logic             back_busy;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic             q_full;
  fbpa_pkg::cmd_t   front_cmd;
  fbpa_pkg::cmd_t   q_cmd;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= 32'd65536;
      block_size  <= 16'd64;
      block_count <= 9'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fbpa_pkg::REG_POOL_BASE:   pool_base   <= pwdata;
        fbpa_pkg::REG_BLOCK_SIZE:  block_size  <= pwdata[15:0];
        fbpa_pkg::REG_BLOCK_COUNT: block_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fbpa_pkg::REG_POOL_BASE:   prdata = pool_base;
      fbpa_pkg::REG_BLOCK_SIZE:  prdata = 32'(block_size);
      fbpa_pkg::REG_BLOCK_COUNT: prdata = 32'(block_count);
      default:                   prdata = '0;
    endcase
  end

  assign over = 32'(block_count) > 32'(MAX_BLOCKS);
  assign cnt  = (block_count == '0) ? CNT_W'(1) :
                over                ? CNT_W'(MAX_BLOCKS) : CNT_W'(block_count);

  assign accept = start & ~busy;
  assign busy   = front_busy | q_valid | back_busy;

  fbpa_front #(
    .ADDR_BITS (ADDR_BITS),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .block_addr (block_addr),
    .pool_base  (pool_base),
    .block_size (block_size),
    .cnt        (cnt),
    .q_full     (q_full),
    .busy       (front_busy),
    .push       (q_push),
    .cmd        (front_cmd)
  );

  fbpa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (front_cmd),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .valid   (q_valid),
    .full    (q_full)
  );

  fbpa_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (q_pop),
    .pool_base   (pool_base),
    .block_size  (block_size),
    .cnt         (cnt),
    .busy        (back_busy),
    .done        (done),
    .status      (status),
    .alloc_addr  (alloc_addr),
    .free_blocks (free_blocks),
    .used_blocks (used_blocks)
  );

  `FBPA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `FBPA_ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `FBPA_ASSERT_IMPLIES(a_empty_zero, clk, rst, done && (status == fbpa_pkg::ST_EMPTY), free_blocks == 9'd0)
  `FBPA_ASSERT_IMPLIES(a_addr_ok, clk, rst, done && (alloc_addr != 32'd0), status == fbpa_pkg::ST_OK)

endmodule
